// ===== design/khs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the byte-wide CRC-16/XMODEM update for the key hash slot block.
// No dependencies; every other file imports this package.
package khs_pkg;

	// slot geometry
	localparam int SLOT_BITS = 14;
	localparam int SLOT_W    = SLOT_BITS;
	localparam logic [15:0] SLOT_MASK = 16'((32'd1 << SLOT_BITS) - 32'd1);

	// CRC-16/XMODEM: poly 0x1021, init 0, no reflection, no final xor
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// hash tag delimiters
	localparam logic [7:0] OPEN_BRACE  = 8'h7B;
	localparam logic [7:0] CLOSE_BRACE = 8'h7D;

	// one key byte handed from the input register to the hash state
	typedef struct packed {
		logic       go;     // byte is consumed this cycle
		logic       last;   // final byte of the key
		logic [7:0] data;
	} khs_step_t;

	// result of the current byte, meaningful when it is the last one
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              used_tag;
	} khs_result_t;

	// one byte through the CRC, MSB first, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/khs_hash_state.sv =====
`timescale 1ns / 1ps
// Running CRC registers and hash tag tracking for one key; forms the slot on the last byte.
// Depends on khs_pkg.
module khs_hash_state import khs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  khs_step_t   step,
	output khs_result_t result
);

	typedef enum logic [1:0] {
		PH_NONE   = 2'd0,
		PH_INSIDE = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	logic [15:0] whole_crc_q, tag_crc_q;
	phase_t      phase_q;
	logic        nonempty_q;

	logic [15:0] whole_crc_d, tag_crc_d, chosen;
	phase_t      phase_d;
	logic        nonempty_d, use_tag;

	// per-byte update of both CRCs and the tag phase
	always_comb begin
		whole_crc_d = crc16_byte(whole_crc_q, step.data);
		tag_crc_d   = tag_crc_q;
		phase_d     = phase_q;
		nonempty_d  = nonempty_q;
		case (phase_q)
			PH_NONE: begin
				if (step.data == OPEN_BRACE) begin
					phase_d = PH_INSIDE;
				end
			end
			PH_INSIDE: begin
				if (step.data == CLOSE_BRACE) begin
					phase_d = PH_CLOSED;
				end else begin
					tag_crc_d  = crc16_byte(tag_crc_q, step.data);
					nonempty_d = 1'b1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// pick the tag CRC only for a closed, non-empty tag
	always_comb begin
		use_tag         = (phase_d == PH_CLOSED) && nonempty_d;
		chosen          = use_tag ? tag_crc_d : whole_crc_d;
		result.slot     = SLOT_W'(chosen & SLOT_MASK);
		result.used_tag = use_tag;
	end

	// state registers; the last byte of a key starts the next key clean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_crc_q <= CRC_INIT;
			tag_crc_q   <= CRC_INIT;
			phase_q     <= PH_NONE;
			nonempty_q  <= 1'b0;
		end else if (step.go) begin
			if (step.last) begin
				whole_crc_q <= CRC_INIT;
				tag_crc_q   <= CRC_INIT;
				phase_q     <= PH_NONE;
				nonempty_q  <= 1'b0;
			end else begin
				whole_crc_q <= whole_crc_d;
				tag_crc_q   <= tag_crc_d;
				phase_q     <= phase_d;
				nonempty_q  <= nonempty_d;
			end
		end
	end

endmodule

// ===== design/key_hash_slot_with_tag_core.sv =====
`timescale 1ns / 1ps
// Top level of the key hash slot block: input register, hash state, result register.
// Depends on khs_pkg and khs_hash_state.
//
// Key bytes enter one word per cycle; a key ends with last_byte set and yields one
// result word, presented from the result register (the input register feeds the hash
// logic, which loads the result register when the last byte moves on). Bytes without
// last_byte yield nothing. The CRC update for a byte is done while it sits in the input
// register, against the running CRC registers, so a new byte can be taken every clock.
// Input is held off only while a finished last byte waits for the result register to
// drain. Slot is the low 14 bits of the CRC-16/XMODEM of the braced hash tag when the
// first '{' is followed by a non-empty region closed by '}', otherwise of the whole key.
// No startup delay after reset.
module key_hash_slot_with_tag_core import khs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        key_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] slot,
	output logic              used_tag
);

	logic              valid_s1, last_s1;
	logic [7:0]        byte_s1;
	logic              s1_go;
	khs_step_t         step;
	khs_result_t       result;
	logic              out_valid_q, used_tag_q;
	logic [SLOT_W-1:0] slot_q;

	// a byte moves on unless it is a last byte facing a full result register
	assign s1_go    = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= key_byte;
			last_s1 <= last_byte;
		end
	end

	assign step = '{go: s1_go, last: last_s1, data: byte_s1};

	khs_hash_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			slot_q     <= result.slot;
			used_tag_q <= result.used_tag;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign used_tag  = used_tag_q;

	// input stalls only behind a last byte blocked by an unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	// a consumed last byte always shows up as a result next cycle
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> out_valid_q)
		else $error("last byte consumed without a result");

	// a non-last byte never creates a result on its own
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !(s1_go && last_s1)) |=> !out_valid_q)
		else $error("result appeared without a last byte");

endmodule

// ===== dv/khs_slot_checker.sv =====
`timescale 1ns / 1ps
// Checker for the key hash slot core: watches both channels, predicts each slot and compares.
// Depends on khs_pkg for widths, delimiters, the CRC polynomial and the result word type.
module khs_slot_checker import khs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        key_byte,
	input  logic              last_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [SLOT_W-1:0] slot,
	input  logic              used_tag,
	output int                errors,
	output int                pending
);

	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_OPEN = 2'd1,
		TAG_DONE = 2'd2
	} tag_phase_e;

	// predicted hash state of the key in flight
	logic [15:0]  key_crc;
	logic [15:0]  tag_crc;
	tag_phase_e   tag_phase;
	logic         tag_filled;
	khs_result_t  slots_due[$];

	// CRC-16/XMODEM, one input bit at a time, MSB first
	function automatic logic [15:0] xmodem_next(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		khs_result_t want;
		khs_result_t got;
		if (!arst_n) begin
			key_crc = 16'h0000;
			tag_crc = 16'h0000;
			tag_phase = TAG_NONE;
			tag_filled = 1'b0;
			slots_due.delete();
		end else begin
			// accepted key word: advance both CRCs and the tag tracker
			if (in_valid && in_ready) begin
				key_crc = xmodem_next(key_crc, key_byte);
				case (tag_phase)
					TAG_NONE: begin
						if (key_byte == OPEN_BRACE)
							tag_phase = TAG_OPEN;
					end
					TAG_OPEN: begin
						if (key_byte == CLOSE_BRACE) begin
							tag_phase = TAG_DONE;
						end else begin
							tag_crc = xmodem_next(tag_crc, key_byte);
							tag_filled = 1'b1;
						end
					end
					default: ;
				endcase
				if (last_byte) begin
					want.used_tag = (tag_phase == TAG_DONE) && tag_filled;
					want.slot = want.used_tag ? tag_crc[SLOT_W-1:0] : key_crc[SLOT_W-1:0];
					slots_due = {slots_due, want};
					key_crc = 16'h0000;
					tag_crc = 16'h0000;
					tag_phase = TAG_NONE;
					tag_filled = 1'b0;
				end
			end
			// accepted result word: compare with the oldest prediction
			if (out_valid && out_ready) begin
				got.slot = slot;
				got.used_tag = used_tag;
				if (slots_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result slot=%h used_tag=%b",
							$realtime, got.slot, got.used_tag);
				end else begin
					want = slots_due.pop_front();
					if (got.slot !== want.slot || got.used_tag !== want.used_tag) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch slot exp=%h got=%h used_tag exp=%b got=%b",
								$realtime, want.slot, got.slot, want.used_tag, got.used_tag);
					end
				end
			end
		end
		pending = slots_due.size();
	end

endmodule

// ===== dv/key_hash_slot_with_tag_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for key_hash_slot_with_tag_core: clock, reset, key stimulus, result back-pressure.
// Depends on khs_pkg, the core and khs_slot_checker, which does all prediction and comparison.
module key_hash_slot_with_tag_core_tb;
	import khs_pkg::*;

	localparam int KEY_WORDS   = 1900;
	localparam int CYCLE_LIMIT = 300000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        key_byte;
	logic              last_byte;
	logic              out_valid;
	logic              out_ready;
	logic [SLOT_W-1:0] slot;
	logic              used_tag;
	int                errors;
	int                pending;

	int          words_sent = 0;
	int          keys_sent = 0;
	logic [7:0]  key_buf[$];
	wire         calm = (words_sent >= 700) && (words_sent < 1000);

	always #2 clk = ~clk;

	key_hash_slot_with_tag_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot      (slot),
		.used_tag  (used_tag)
	);

	khs_slot_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.slot      (slot),
		.used_tag  (used_tag),
		.errors    (errors),
		.pending   (pending)
	);

	// any byte that is not a brace
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == OPEN_BRACE || b == CLOSE_BRACE)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// full range, with braces made common
	function automatic logic [7:0] any_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return OPEN_BRACE;
		if (pick < 12)
			return CLOSE_BRACE;
		return 8'($urandom_range(255));
	endfunction

	// put one byte at the tail of the key being built
	task automatic append_byte(input logic [7:0] b);
		key_buf = {key_buf, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	task automatic add_plain(input int n);
		for (int i = 0; i < n; i++)
			append_byte(plain_byte());
	endtask

	task automatic add_any(input int n);
		for (int i = 0; i < n; i++)
			append_byte(any_byte());
	endtask

	// build one random key, mostly with a well-formed tag
	task automatic build_random_key();
		int kind;
		kind = $urandom_range(99);
		if (kind < 55) begin
			add_plain($urandom_range(4));
			append_byte(OPEN_BRACE);
			if ($urandom_range(3) == 0)
				add_any($urandom_range(1, 5));
			else
				add_plain($urandom_range(1, 5));
			while (key_buf[key_buf.size()-1] == CLOSE_BRACE)
				void'(key_buf.pop_back());
			append_byte(CLOSE_BRACE);
			add_any($urandom_range(4));
		end else if (kind < 65) begin
			// empty tag, sometimes followed by a real one
			add_plain($urandom_range(3));
			add_text("{}");
			if ($urandom_range(1)) begin
				append_byte(OPEN_BRACE);
				add_plain($urandom_range(1, 3));
				append_byte(CLOSE_BRACE);
			end
			add_any($urandom_range(3));
		end else if (kind < 75) begin
			// open brace never closed
			add_plain($urandom_range(3));
			append_byte(OPEN_BRACE);
			add_any($urandom_range(6));
			for (int i = 0; i < key_buf.size(); i++)
				if (key_buf[i] == CLOSE_BRACE)
					key_buf[i] = 8'h00;
		end else if (kind < 90) begin
			add_any($urandom_range(1, 10));
		end else begin
			add_any(1);
		end
	endtask

	// offer every word of key_buf, last flag on the final one
	task automatic send_key();
		int n;
		for (n = 0; n < key_buf.size(); n++) begin
			while (!calm && $urandom_range(99) < 33) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			key_byte <= key_buf[n];
			last_byte <= (n == key_buf.size() - 1);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			words_sent++;
			@(negedge clk);
		end
		keys_sent++;
		key_buf.delete();
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_key();
	endtask

	// result side: random stalls, one long hold-off, a calm stretch
	initial begin : result_side
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && keys_sent >= 40) begin
				hold_done = 1'b1;
				hold_left = 80;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 33);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_byte = 8'h00;
		last_byte = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, tag forms, stray braces
		append_byte(8'h00);
		send_key();
		append_byte(8'hFF);
		send_key();
		send_text("{a}");
		send_text("{}");
		send_text("{}{x}");
		send_text("{ab");
		send_text("}{z}");
		send_text("{{}}");

		while (words_sent < KEY_WORDS) begin
			build_random_key();
			send_key();
		end
		in_valid <= 1'b0;

		// drain until no predicted result is pending, then let the clock run on before the verdict
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
design/khs_pkg.sv
design/khs_hash_state.sv
design/key_hash_slot_with_tag_core.sv
dv/khs_slot_checker.sv
dv/key_hash_slot_with_tag_core_tb.sv
